@@ rtl/ffba_pkg.sv @@
// Shared types and constants for the first-fit block allocator.
// Depends on nothing.
package ffba_pkg;

    localparam int unsigned OFF_W  = 20;
    localparam int unsigned SIZE_W = 21;
    localparam int unsigned ST_W   = 3;

    localparam logic [ST_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOFIT    = 3'd2;
    localparam logic [ST_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [ST_W-1:0] ST_BADREL   = 3'd4;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // One table entry as it moves along the cell row.
    typedef struct packed {
        logic              used;
        logic              free;
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MERGE,
        S_DONE
    } t_state;

endpackage

@@ rtl/first_fit_block_allocator_core.sv @@
// First-fit allocator top level: cell row rotated past one inspection point.
// Depends on ffba_pkg and ffba_cell.
//
// Use: an item enters on i_valid/o_stall: i_cmd chooses allocate or release,
// i_req_size or i_release_offset carries the argument. One result item leaves
// on o_valid/i_stall with o_payload_offset and o_status.
//
// The table lives in a row of MAX_BLOCKS cells. Every working cycle the row
// shifts by one place (cell 0 takes cell 1, the last cell takes what the
// head logic produces), so each entry passes the head once per pass.
// A zero-size request goes straight to its result. Any other item takes
// one full pass to find, split or mark, and good releases take a second
// pass that merges adjacent free runs and packs the table. The block goes
// back to idle once the result leaves and takes one item at a time.
// A split inserts an entry, so the head holds one pending entry while the
// rest shifts; it drains into the first unused slot, which a non-full
// table always has after the split point.
// Between items no two free entries sit side by side, so a release joins
// at most three entries; the merge pass writes the joined entry and then
// reads one or two cells ahead, closing the gap.
// Reset (synchronous, active low) gives one free block covering the arena
// less a header. While the receiver stalls, the result is held and no new
// item is taken.
module first_fit_block_allocator_core #(
    parameter int unsigned ARENA_BYTES  = 1048576,
    parameter int unsigned HEADER_BYTES = 16,
    parameter int unsigned ALIGN_BYTES  = 8,
    parameter int unsigned MAX_BLOCKS   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [20:0] i_req_size,
    input  logic [19:0] i_release_offset,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [19:0] o_payload_offset,
    output logic [2:0]  o_status
);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned SW = ffba_pkg::SIZE_W;
    localparam int unsigned OW = ffba_pkg::OFF_W;
    localparam logic [SW-1:0] HDR  = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] ALN  = SW'(ALIGN_BYTES);
    localparam logic [SW-1:0] INIT = SW'(ARENA_BYTES - HEADER_BYTES);

    ffba_pkg::t_state r_state, n_state;
    ffba_pkg::t_entry q [MAX_BLOCKS];
    ffba_pkg::t_entry tail_d;
    ffba_pkg::t_entry c_init;
    logic             shift;

    logic [CW-1:0]    r_cnt;       // cycles into the pass
    logic [CW-1:0]    r_bcount;    // block count
    logic             r_cmd;
    logic [SW+2:0]    r_need;      // rounded size, room for overflow
    logic [OW-1:0]    r_off;
    logic             r_done;      // found / matched in this pass
    logic             r_hold_v;    // pending inserted entry
    ffba_pkg::t_entry r_hold;
    logic [1:0]       r_skip;      // merge: entries joined so far
    logic             r_ov;
    logic [OW-1:0]    r_ooff;
    logic [2:0]       r_ost;

    assign c_init = '{used: 1'b1, free: 1'b1, start: '0, size: INIT};

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_row
        ffba_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_rst_val(g == 0),
            .i_init   (c_init),
            .i_load   (shift),
            .i_d      ((g == MAX_BLOCKS - 1) ? tail_d : q[(g + 1) % MAX_BLOCKS]),
            .o_q      (q[g])
        );
    end

    ffba_pkg::t_entry h;
    assign h = q[0];

    logic [SW+2:0] need_c;
    assign need_c = ((SW+3)'(i_req_size) + (SW+3)'(ALIGN_BYTES - 1))
                    & ~((SW+3)'(ALIGN_BYTES - 1));

    logic          fit, split, match;
    logic [SW+2:0] hsz;
    assign hsz   = (SW+3)'(h.size);
    assign fit   = h.used && h.free && hsz >= r_need && !r_done;
    assign split = fit && hsz >= r_need + (SW+3)'(HDR) + (SW+3)'(ALN)
                   && r_bcount < CW'(MAX_BLOCKS);
    assign match = h.used && !r_done
                   && ({1'b0, h.start} + (OW+1)'(HEADER_BYTES)) == {1'b0, r_off};

    logic last;
    assign last  = r_cnt == CW'(MAX_BLOCKS - 1);
    assign shift = (r_state == ffba_pkg::S_SCAN) || (r_state == ffba_pkg::S_MERGE);

    // merge: look one and two cells past the head, never across the pass end
    ffba_pkg::t_entry n1, n2, ahead;
    logic             join1, join2, ahead_ok;
    logic [CW:0]      ahead_idx;
    logic [SW-1:0]    sum2, sum3;
    assign n1    = q[1 % MAX_BLOCKS];
    assign n2    = q[2 % MAX_BLOCKS];
    assign join1 = h.used && h.free && n1.used && n1.free
                   && ({1'b0, r_cnt} + (CW+1)'(1)) < (CW+1)'(MAX_BLOCKS);
    assign join2 = join1 && n2.used && n2.free
                   && ({1'b0, r_cnt} + (CW+1)'(2)) < (CW+1)'(MAX_BLOCKS);
    assign sum2  = h.size + HDR + n1.size;
    assign sum3  = sum2 + HDR + n2.size;
    assign ahead_idx = {1'b0, r_cnt} + (CW+1)'(r_skip);
    assign ahead_ok  = ahead_idx < (CW+1)'(MAX_BLOCKS);

    always_comb begin
        case (r_skip)
            2'd1:    ahead = n1;
            2'd2:    ahead = n2;
            default: ahead = h;
        endcase
    end

    // tail: what is written into the far end of the row this cycle
    always_comb begin
        tail_d = h;
        n_state = r_state;
        case (r_state)
            ffba_pkg::S_SCAN: begin
                if (r_cmd == ffba_pkg::CMD_ALLOC) begin
                    if (r_hold_v) begin
                        tail_d = r_hold;        // pending entry goes in, head waits
                    end
                    if (fit) begin
                        tail_d.free = 1'b0;
                        if (split) tail_d.size = SW'(r_need);
                    end
                    if (r_hold_v && !h.used) begin
                        tail_d = r_hold;        // drop the unused slot
                    end
                end else if (match) begin
                    tail_d.free = 1'b1;
                end
                if (last) begin
                    n_state = (r_cmd == ffba_pkg::CMD_RELEASE && (r_done || match))
                              ? ffba_pkg::S_MERGE : ffba_pkg::S_DONE;
                end
            end
            ffba_pkg::S_MERGE: begin
                if (r_skip == 2'd0 && join1) begin
                    tail_d      = h;
                    tail_d.size = join2 ? sum3 : sum2;
                end else if (!ahead_ok) begin
                    tail_d = '0;
                end else begin
                    tail_d = ahead;
                end
                if (last) n_state = ffba_pkg::S_DONE;
            end
            ffba_pkg::S_DONE: begin
                if (!i_stall) n_state = ffba_pkg::S_IDLE;
            end
            default: begin
                if (i_valid) begin
                    n_state = (i_cmd == ffba_pkg::CMD_ALLOC && i_req_size == '0)
                              ? ffba_pkg::S_DONE : ffba_pkg::S_SCAN;
                end
            end
        endcase
    end

    // Insertion order fix: when holding, the head entry is not consumed; to
    // keep a plain shift row, the hold register instead swaps with the head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffba_pkg::S_IDLE;
            r_bcount <= CW'(1);
            r_cnt    <= '0;
            r_done   <= 1'b0;
            r_hold_v <= 1'b0;
            r_skip   <= 2'd0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ffba_pkg::S_IDLE: begin
                    r_cnt    <= '0;
                    r_done   <= 1'b0;
                    r_hold_v <= 1'b0;
                    r_skip   <= 2'd0;
                    if (i_valid) begin
                        r_cmd  <= i_cmd;
                        r_need <= need_c;
                        r_off  <= i_release_offset;
                        r_ost  <= ffba_pkg::ST_ZERO;
                        r_ooff <= '0;
                        r_ov   <= i_cmd == ffba_pkg::CMD_ALLOC && i_req_size == '0;
                    end
                end
                ffba_pkg::S_SCAN: begin
                    r_cnt <= last ? '0 : r_cnt + CW'(1);
                    if (r_cmd == ffba_pkg::CMD_ALLOC) begin
                        if (r_hold_v) begin
                            r_hold <= h.used ? h : r_hold;
                            r_hold_v <= h.used;
                        end
                        if (fit) begin
                            r_done <= 1'b1;
                            r_ooff <= h.start + OW'(HEADER_BYTES);
                            if (split) begin
                                r_hold_v <= 1'b1;
                                r_hold   <= '{used: 1'b1, free: 1'b1,
                                    start: h.start + OW'(HEADER_BYTES) + OW'(r_need),
                                    size: h.size - SW'(r_need) - HDR};
                                r_bcount <= r_bcount + CW'(1);
                            end
                        end
                    end else if (match) begin
                        r_done <= 1'b1;
                    end
                    if (last) begin
                        if (r_cmd == ffba_pkg::CMD_ALLOC) begin
                            r_ov  <= 1'b1;
                            r_ost <= (r_done || fit) ? ffba_pkg::ST_GRANTED
                                                     : ffba_pkg::ST_NOFIT;
                            if (!(r_done || fit)) r_ooff <= '0;
                        end else if (!(r_done || match)) begin
                            r_ov  <= 1'b1;
                            r_ost <= ffba_pkg::ST_BADREL;
                        end
                    end
                end
                ffba_pkg::S_MERGE: begin
                    r_cnt <= last ? '0 : r_cnt + CW'(1);
                    if (r_skip == 2'd0 && join1) begin
                        r_skip <= join2 ? 2'd2 : 2'd1;
                    end
                    if (last) begin
                        r_bcount <= r_bcount - CW'(r_skip);
                        r_ov     <= 1'b1;
                        r_ost    <= ffba_pkg::ST_RELEASED;
                        r_ooff   <= '0;
                    end
                end
                ffba_pkg::S_DONE: begin
                    if (!i_stall) r_ov <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_stall          = r_state != ffba_pkg::S_IDLE;
    assign o_valid          = r_ov && r_state == ffba_pkg::S_DONE;
    assign o_payload_offset = r_ooff;
    assign o_status         = r_ost;
endmodule

@@ rtl/ffba_cell.sv @@
// One storage cell of the block table: holds one entry.
// Depends on ffba_pkg.
module ffba_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rst_val,  // when set, reset loads the used free arena block; else the cell clears
    input  ffba_pkg::t_entry i_init,
    input  logic            i_load,
    input  ffba_pkg::t_entry i_d,
    output ffba_pkg::t_entry o_q
);
    ffba_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= i_rst_val ? i_init : '0;
        end else if (i_load) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule

@@ rtl/ffba_checker.sv @@
// Port-level checks for the allocator; bound to the top level.
// Depends on ffba_pkg.
module ffba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [19:0] o_payload_offset,
    input logic [2:0]  o_status
);
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ffba_pkg::ST_BADREL)
        else $error("status code out of range");
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ffba_pkg::ST_GRANTED |-> o_payload_offset == '0)
        else $error("offset given without grant");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result shown while taking items");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("stalled result changed");
endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);

@@ dv/first_fit_block_allocator_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for first_fit_block_allocator_core: table-driven directed
// items, then random allocate/release traffic, checked against a local predictor.
// Depends on ffba_pkg and the allocator top level.
module first_fit_block_allocator_core_tb;

    localparam int unsigned ARENA  = 1048576;
    localparam int unsigned HDR    = 16;
    localparam int unsigned ALIGN  = 8;
    localparam int unsigned NBLK   = 256;
    localparam int unsigned LAT    = 2 * NBLK + 8;
    localparam int unsigned DOG_LIMIT = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_cmd;
    logic [20:0]       i_req_size;
    logic [19:0]       i_release_offset;
    logic              o_valid;
    logic              i_stall;
    logic [19:0]       o_payload_offset;
    logic [2:0]        o_status;

    first_fit_block_allocator_core dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd, .i_req_size,
        .i_release_offset, .o_valid, .i_stall, .o_payload_offset, .o_status
    );

    typedef struct packed {
        logic [19:0] offset;
        logic [2:0]  status;
    } t_grant;

    // directed row: command, argument, and a typed-in answer where obvious
    typedef struct {
        logic        cmd;
        logic [20:0] size;
        logic [19:0] off;
        bit          fixed;
        logic [19:0] want_off;
        logic [2:0]  want_st;
    } t_row;

    // predictor copy of the block table
    logic [19:0] tbl_start [NBLK];
    logic [20:0] tbl_size  [NBLK];
    bit          tbl_free  [NBLK];
    int unsigned tbl_count;

    t_grant      grant_q [$];
    logic [19:0] live_q  [$];   // payload offsets currently held
    int unsigned n_in, n_out, n_bad, n_alloc, n_rel, n_full;
    int unsigned dog;
    bit          hold_long, timed_out;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic table_reset();
        for (int k = 0; k < NBLK; k++) begin
            tbl_start[k] = '0;
            tbl_size[k]  = '0;
            tbl_free[k]  = 1'b0;
        end
        tbl_size[0] = 21'(ARENA - HDR);
        tbl_free[0] = 1'b1;
        tbl_count   = 1;
    endtask

    function automatic void merge_runs();
        int unsigned w;
        w = 0;
        for (int unsigned r = 0; r < tbl_count; r++) begin
            if (w > 0 && tbl_free[w-1] && tbl_free[r]) begin
                tbl_size[w-1] = tbl_size[w-1] + 21'(HDR) + tbl_size[r];
            end else begin
                tbl_start[w] = tbl_start[r];
                tbl_size[w]  = tbl_size[r];
                tbl_free[w]  = tbl_free[r];
                w++;
            end
        end
        for (int unsigned r = w; r < NBLK; r++) begin
            tbl_start[r] = '0;
            tbl_size[r]  = '0;
            tbl_free[r]  = 1'b0;
        end
        tbl_count = w;
    endfunction

    function automatic t_grant predict_grant(logic cmd, logic [20:0] size, logic [19:0] off);
        t_grant g;
        longint need;
        g = '{offset: '0, status: ffba_pkg::ST_NOFIT};
        if (cmd == ffba_pkg::CMD_ALLOC) begin
            if (size == 0) begin
                g.status = ffba_pkg::ST_ZERO;
                return g;
            end
            need = (longint'(size) + ALIGN - 1) / ALIGN * ALIGN;
            for (int unsigned i = 0; i < tbl_count; i++) begin
                if (tbl_free[i] && longint'(tbl_size[i]) >= need) begin
                    if (longint'(tbl_size[i]) >= need + HDR + ALIGN && tbl_count < NBLK) begin
                        for (int unsigned k = tbl_count; k > i + 1; k--) begin
                            tbl_start[k] = tbl_start[k-1];
                            tbl_size[k]  = tbl_size[k-1];
                            tbl_free[k]  = tbl_free[k-1];
                        end
                        tbl_start[i+1] = tbl_start[i] + 20'(HDR) + 20'(need);
                        tbl_size[i+1]  = tbl_size[i] - 21'(need) - 21'(HDR);
                        tbl_free[i+1]  = 1'b1;
                        tbl_size[i]    = 21'(need);
                        tbl_count++;
                    end
                    tbl_free[i] = 1'b0;
                    g.offset = tbl_start[i] + 20'(HDR);
                    g.status = ffba_pkg::ST_GRANTED;
                    return g;
                end
            end
            return g;
        end
        g.status = ffba_pkg::ST_BADREL;
        for (int unsigned i = 0; i < tbl_count; i++) begin
            if (21'(tbl_start[i]) + 21'(HDR) == 21'(off)) begin
                tbl_free[i] = 1'b1;
                merge_runs();
                g.status = ffba_pkg::ST_RELEASED;
                return g;
            end
        end
        return g;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one item and hold it until accepted
    task automatic send_item(logic cmd, logic [20:0] size, logic [19:0] off,
                             bit fixed, logic [19:0] w_off, logic [2:0] w_st);
        t_grant g;
        g = predict_grant(cmd, size, off);
        if (fixed && (g.offset != w_off || g.status != w_st))
            $display("note: directed answer disagrees with predictor");
        if (fixed) g = '{offset: w_off, status: w_st};
        i_valid          <= 1'b1;
        i_cmd            <= cmd;
        i_req_size       <= size;
        i_release_offset <= off;
        do @(posedge i_clk); while (o_stall);
        grant_q.push_back(g);
        n_in++;
        if (g.status == ffba_pkg::ST_GRANTED) begin
            live_q.push_back(g.offset);
            n_alloc++;
        end
        if (g.status == ffba_pkg::ST_RELEASED) begin
            n_rel++;
            foreach (live_q[k]) if (live_q[k] == off) begin
                live_q.delete(k);
                break;
            end
        end
        if (tbl_count == NBLK) n_full++;
    endtask

    task automatic idle_cycles(int unsigned n);
        if (n == 0) return;
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (grant_q.size() != 0 && !timed_out) @(posedge i_clk);
    endtask

    // result side: random stall, one long hold-off on request
    initial begin
        int unsigned g;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (3 * LAT) @(posedge i_clk);
                hold_long = 1'b0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g != 0) begin
                i_stall <= 1'b1;
                repeat (g) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    // checker: oldest expectation against each accepted result
    always @(posedge i_clk) begin
        t_grant exp_g;
        if (i_rst_n && o_valid && !i_stall) begin
            n_out++;
            if (grant_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result st=%0d off=%0h", o_status,
                                          o_payload_offset);
            end else begin
                exp_g = grant_q.pop_front();
                if (o_status !== exp_g.status || o_payload_offset !== exp_g.offset) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch #%0d: exp st=%0d off=%0h, got st=%0d off=%0h",
                                 n_out, exp_g.status, exp_g.offset, o_status,
                                 o_payload_offset);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) dog <= 0;
        else dog <= dog + 1;
        if (dog >= DOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_row        rows [$];
        logic [20:0] sz;
        logic [19:0] off;
        int unsigned r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = ffba_pkg::CMD_ALLOC;
        i_req_size = '0;
        i_release_offset = '0;
        hold_long = 1'b0;
        timed_out = 1'b0;
        dog = 0;
        n_in = 0; n_out = 0; n_bad = 0; n_alloc = 0; n_rel = 0; n_full = 0;
        table_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        rows = '{
            '{ffba_pkg::CMD_ALLOC,   21'd0,       20'd0,     1, 20'd0,  ffba_pkg::ST_ZERO},
            '{ffba_pkg::CMD_RELEASE, 21'd0,       20'd0,     1, 20'd0,  ffba_pkg::ST_BADREL},
            '{ffba_pkg::CMD_ALLOC,   21'h1FFFFF,  20'd0,     1, 20'd0,  ffba_pkg::ST_NOFIT},
            '{ffba_pkg::CMD_ALLOC,   21'd1048576, 20'd0,     1, 20'd0,  ffba_pkg::ST_NOFIT},
            '{ffba_pkg::CMD_ALLOC,   21'd1,       20'hFFFFF, 1, 20'd16, ffba_pkg::ST_GRANTED},
            '{ffba_pkg::CMD_ALLOC,   21'd8,       20'd0,     1, 20'd40, ffba_pkg::ST_GRANTED},
            '{ffba_pkg::CMD_ALLOC,   21'd9,       20'd0,     0, 20'd0,  ffba_pkg::ST_GRANTED},
            '{ffba_pkg::CMD_RELEASE, 21'h1FFFFF,  20'd40,    1, 20'd0,  ffba_pkg::ST_RELEASED},
            '{ffba_pkg::CMD_RELEASE, 21'd0,       20'd40,    1, 20'd0,  ffba_pkg::ST_RELEASED},
            '{ffba_pkg::CMD_RELEASE, 21'd0,       20'd41,    1, 20'd0,  ffba_pkg::ST_BADREL},
            '{ffba_pkg::CMD_RELEASE, 21'd0,       20'hFFFFF, 1, 20'd0,  ffba_pkg::ST_BADREL},
            '{ffba_pkg::CMD_ALLOC,   21'd3,       20'd0,     0, 20'd0,  ffba_pkg::ST_GRANTED},
            '{ffba_pkg::CMD_RELEASE, 21'd0,       20'd16,    0, 20'd0,  ffba_pkg::ST_RELEASED},
            '{ffba_pkg::CMD_ALLOC,   21'd1048552, 20'd0,     0, 20'd0,  ffba_pkg::ST_GRANTED},
            '{ffba_pkg::CMD_ALLOC,   21'd1048560, 20'd0,     0, 20'd0,  ffba_pkg::ST_GRANTED}
        };
        foreach (rows[k]) begin
            send_item(rows[k].cmd, rows[k].size, rows[k].off, rows[k].fixed,
                      rows[k].want_off, rows[k].want_st);
            idle_cycles(gap_len());
        end
        wait_drained();

        // fill the table past its limit: small allocations, receiver held off
        hold_long = 1'b1;
        for (int k = 0; k < 300; k++) begin
            send_item(ffba_pkg::CMD_ALLOC, 21'($urandom_range(1, 64)), 20'($urandom),
                      0, '0, '0);
            if (k % 40 == 0) idle_cycles(gap_len());
        end
        // sender pauses until all results are back
        wait_drained();

        // random traffic: mostly valid releases of live blocks and modest sizes
        for (int k = 0; k < 540; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                sz = (r < 3) ? 21'($urandom) : 21'($urandom_range(1, 4096));
                send_item(ffba_pkg::CMD_ALLOC, sz, 20'($urandom), 0, '0, '0);
            end else if (r < 85 && live_q.size() != 0) begin
                off = live_q[$urandom_range(0, live_q.size() - 1)];
                send_item(ffba_pkg::CMD_RELEASE, 21'($urandom), off, 0, '0, '0);
            end else if (r < 92) begin
                send_item(ffba_pkg::CMD_ALLOC, 21'($urandom_range(0, 2)) * 21'h80000,
                          20'($urandom), 0, '0, '0);
            end else begin
                send_item(ffba_pkg::CMD_RELEASE, 21'($urandom), 20'($urandom), 0, '0, '0);
            end
            if ($urandom_range(0, 5) != 0) idle_cycles(gap_len());
        end

        wait_drained();
        repeat (LAT) @(posedge i_clk);
        $display("%0d items sent, %0d results: %0d grants, %0d releases, %0d with table full",
                 n_in, n_out, n_alloc, n_rel, n_full);
        $display("%0d mismatches, %0d expectations outstanding", n_bad, grant_q.size());
        if (n_bad == 0 && grant_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ first_fit_block_allocator_core.f @@
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/first_fit_block_allocator_core.sv
rtl/ffba_checker.sv
dv/first_fit_block_allocator_core_tb.sv
